>>> hw/rtl/quad_grid_point_mapper_defines.svh
// Assertion macros shared by the mapper RTL.
`ifndef QUAD_GRID_POINT_MAPPER_DEFINES_SVH
`define QUAD_GRID_POINT_MAPPER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define QGPM_ASSERT_SAME(label, clk_s, rstn_s, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("qgpm: same-cycle check failed");
// Next-cycle implication.
`define QGPM_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("qgpm: next-cycle check failed");
`else
`define QGPM_ASSERT_SAME(label, clk_s, rstn_s, ante, cons)
`define QGPM_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons)
`endif

`endif

>>> hw/rtl/qgpm_pkg.sv
package qgpm_pkg;

	// parameter defaults
	localparam int MAX_GRID_DEF  = 4096;
	localparam int FRAC_BITS_DEF = 16;

	// fixed field widths
	localparam int CORNER_W  = 64;
	localparam int COORD_W   = 32;
	localparam int FIELD_W   = 13;
	localparam int CFG_IDX_W = 3;

	// offset magnitude limit is 2^OFF_LOG2
	localparam int OFF_LOG2 = 40;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TOP_LEFT,
		REG_TOP_RIGHT,
		REG_BOTTOM_RIGHT,
		REG_BOTTOM_LEFT,
		REG_GRID_WIDTH,
		REG_GRID_HEIGHT
	} cfg_reg_t;

	typedef struct packed {
		logic [FIELD_W-1:0] grid_col;
		logic [FIELD_W-1:0] grid_row;
	} in_item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] mapped_x;
		logic signed [COORD_W-1:0] mapped_y;
		logic                      degenerate;
	} out_item_t;

endpackage

>>> hw/rtl/qgpm_div_cell.sv
// One restoring-division step for a set of lanes, registered.
module qgpm_div_cell #(
	parameter int LANES  = 1,
	parameter int DEN_W  = 8,
	parameter int Q_W    = 8,
	parameter int SIDE_W = 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          vld_i,
	input  logic [LANES-1:0][DEN_W-1:0]   rem_i,
	input  logic [LANES-1:0][DEN_W-1:0]   den_i,
	input  logic [LANES-1:0][Q_W-1:0]     lq_i,
	input  logic [SIDE_W-1:0]             side_i,
	output logic                          vld_o,
	output logic [LANES-1:0][DEN_W-1:0]   rem_o,
	output logic [LANES-1:0][DEN_W-1:0]   den_o,
	output logic [LANES-1:0][Q_W-1:0]     lq_o,
	output logic [SIDE_W-1:0]             side_o
);

	logic [LANES-1:0][DEN_W:0]   trial;
	logic [LANES-1:0][DEN_W:0]   diff;
	logic [LANES-1:0]            ge;
	logic [LANES-1:0][DEN_W-1:0] rem_nxt;
	logic [LANES-1:0][Q_W-1:0]   lq_nxt;

	logic                        vld_q;
	logic [LANES-1:0][DEN_W-1:0] rem_q;
	logic [LANES-1:0][DEN_W-1:0] den_q;
	logic [LANES-1:0][Q_W-1:0]   lq_q;
	logic [SIDE_W-1:0]           side_q;

	// shift in next dividend bit, trial subtract
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			trial[l]   = {rem_i[l], lq_i[l][Q_W-1]};
			diff[l]    = trial[l] - {1'b0, den_i[l]};
			ge[l]      = (trial[l] >= {1'b0, den_i[l]});
			rem_nxt[l] = ge[l] ? diff[l][DEN_W-1:0] : trial[l][DEN_W-1:0];
			lq_nxt[l]  = {lq_i[l][Q_W-2:0], ge[l]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= rem_nxt;
			den_q  <= den_i;
			lq_q   <= lq_nxt;
			side_q <= side_i;
		end
	end

	assign vld_o  = vld_q;
	assign rem_o  = rem_q;
	assign den_o  = den_q;
	assign lq_o   = lq_q;
	assign side_o = side_q;

endmodule

>>> hw/rtl/qgpm_div_pipe.sv
// Row of division cells, one quotient bit per cell, all lanes in lockstep.
module qgpm_div_pipe #(
	parameter int LANES  = 1,
	parameter int DEN_W  = 8,
	parameter int Q_W    = 8,
	parameter int SIDE_W = 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        vld_i,
	input  logic [LANES-1:0][DEN_W-1:0] rem_i,
	input  logic [LANES-1:0][DEN_W-1:0] den_i,
	input  logic [LANES-1:0][Q_W-1:0]   lq_i,
	input  logic [SIDE_W-1:0]           side_i,
	output logic                        vld_o,
	output logic [LANES-1:0][Q_W-1:0]   quot_o,
	output logic [SIDE_W-1:0]           side_o
);

	logic [Q_W:0]                        c_vld;
	logic [Q_W:0][LANES-1:0][DEN_W-1:0]  c_rem;
	logic [Q_W:0][LANES-1:0][DEN_W-1:0]  c_den;
	logic [Q_W:0][LANES-1:0][Q_W-1:0]    c_lq;
	logic [Q_W:0][SIDE_W-1:0]            c_side;

	assign c_vld[0]  = vld_i;
	assign c_rem[0]  = rem_i;
	assign c_den[0]  = den_i;
	assign c_lq[0]   = lq_i;
	assign c_side[0] = side_i;

	// cell g resolves quotient bit Q_W-1-g
	for (genvar g = 0; g < Q_W; g++) begin : g_cell
		qgpm_div_cell #(
			.LANES  (LANES),
			.DEN_W  (DEN_W),
			.Q_W    (Q_W),
			.SIDE_W (SIDE_W)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld_i  (c_vld[g]),
			.rem_i  (c_rem[g]),
			.den_i  (c_den[g]),
			.lq_i   (c_lq[g]),
			.side_i (c_side[g]),
			.vld_o  (c_vld[g+1]),
			.rem_o  (c_rem[g+1]),
			.den_o  (c_den[g+1]),
			.lq_o   (c_lq[g+1]),
			.side_o (c_side[g+1])
		);
	end

	assign vld_o  = c_vld[Q_W];
	assign quot_o = c_lq[Q_W];
	assign side_o = c_side[Q_W];

endmodule

>>> hw/rtl/quad_grid_point_mapper.sv
// Channel   | Signals                        | Transfer when
// ----------+--------------------------------+------------------------------
// config    | cfg_wr_en cfg_index cfg_data   | cfg_wr_en high
// input     | in_valid in_stall in_data      | in_valid high, in_stall low
// output    | out_valid out_stall out_data   | out_valid high, out_stall low
//
// One grid point per cycle; a point needs 84 register stages from the input
// transfer to the earliest output transfer: two entry stages, a 33-cell row
// for the side-point divisions, seven stages of products and magnitudes, a
// 41-cell row for the intersection divide and the output register.
// Reset puts the corners at zero, grid sizes at one and clears all valids.
// A stalled result parks in a one-entry skid register; while it is full the
// whole pipeline holds and in_stall is high.
module quad_grid_point_mapper
	import qgpm_pkg::*;
#(
	parameter int MAX_GRID  = MAX_GRID_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CORNER_W-1:0]  cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_data
);

`include "quad_grid_point_mapper_defines.svh"

	localparam int NL    = 8;                       // side-point lanes
	localparam int GW    = $clog2(MAX_GRID + 1);    // grid size bits
	localparam int DW    = GW + 1;                  // side divisor 2*d
	localparam int MW    = COORD_W + 1;             // coordinate difference
	localparam int LNW   = MW + 1 + GW;             // 2*m*k + d
	localparam int LQW   = MW;                      // side quotient
	localparam int PW    = 2 * MW;                  // cross product
	localparam int NDW   = PW + 1;                  // det / numerator
	localparam int ABSW  = PW;                      // their magnitudes
	localparam int DVAW  = COORD_W;                 // |direction|
	localparam int SPLIT = 33;                      // multiplier split point
	localparam int N2W   = ABSW + DVAW + 2;         // rounded dividend
	localparam int SDW   = ABSW + 1;                // divisor 2*|det|
	localparam int SQW   = OFF_LOG2 + 1;            // offset quotient
	localparam int VW    = SQW + 1;                 // base plus offset
	localparam int SIDEW = 5 + 2 * COORD_W;
	localparam logic [63:0] DEG_LIMIT =
		((64'd1 << (2 * FRAC_BITS)) - 64'd1) / 64'd1000000000;
	localparam logic [SQW-1:0] OFF_LIMIT = {1'b1, {OFF_LOG2{1'b0}}};

	function automatic logic [GW-1:0] eff_size(input logic [FIELD_W-1:0] r);
		int v;
		v = int'(r);
		if (v == 0) begin
			v = 1;
		end else if (v > MAX_GRID) begin
			v = MAX_GRID;
		end
		return GW'(v);
	endfunction

	function automatic logic [MW-1:0] sext(input logic [COORD_W-1:0] v);
		return {v[COORD_W-1], v};
	endfunction

	function automatic logic [COORD_W-1:0] place(input logic [COORD_W-1:0] base,
		input logic [SQW-1:0] q, input logic over, input logic neg);
		logic [SQW-1:0] qm;
		logic [VW-1:0]  b;
		logic [VW-1:0]  v;
		qm = (over || (q > OFF_LIMIT)) ? OFF_LIMIT : q;
		b  = {{(VW-COORD_W){base[COORD_W-1]}}, base};
		v  = neg ? (b - VW'(qm)) : (b + VW'(qm));
		if (!v[VW-1] && (|v[VW-2:COORD_W-1])) begin
			return {1'b0, {(COORD_W-1){1'b1}}};
		end else if (v[VW-1] && !(&v[VW-2:COORD_W-1])) begin
			return {1'b1, {(COORD_W-1){1'b0}}};
		end
		return v[COORD_W-1:0];
	endfunction

	// ---------------- configuration registers ----------------
	logic [3:0][CORNER_W-1:0] corner_q;
	logic [FIELD_W-1:0]       grid_w_q;
	logic [FIELD_W-1:0]       grid_h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_q <= '0;
			grid_w_q <= FIELD_W'(1);
			grid_h_q <= FIELD_W'(1);
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_TOP_LEFT:     corner_q[0] <= cfg_data;
				REG_TOP_RIGHT:    corner_q[1] <= cfg_data;
				REG_BOTTOM_RIGHT: corner_q[2] <= cfg_data;
				REG_BOTTOM_LEFT:  corner_q[3] <= cfg_data;
				REG_GRID_WIDTH:   grid_w_q <= cfg_data[FIELD_W-1:0];
				REG_GRID_HEIGHT:  grid_h_q <= cfg_data[FIELD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	logic [3:0][COORD_W-1:0] cxv, cyv;
	logic [GW-1:0]           w_eff, h_eff, gx_c, gy_c;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			cxv[i] = corner_q[i][CORNER_W-1:COORD_W];
			cyv[i] = corner_q[i][COORD_W-1:0];
		end
	end

	assign w_eff = eff_size(grid_w_q);
	assign h_eff = eff_size(grid_h_q);

	// clamp points beyond the grid onto its edge
	assign gx_c = (int'(in_data.grid_col) > int'(w_eff)) ? w_eff : GW'(in_data.grid_col);
	assign gy_c = (int'(in_data.grid_row) > int'(h_eff)) ? h_eff : GW'(in_data.grid_row);

	// ---------------- flow control ----------------
	logic en;
	logic skid_vld_q, out_vld_q;
	out_item_t skid_q, out_q;

	assign en       = !skid_vld_q;
	assign in_stall = skid_vld_q;

	// ---------------- side-point lanes ----------------
	// lanes: left x/y, right x/y, top x/y, bottom x/y
	logic [NL-1:0][COORD_W-1:0] la, lb;
	logic [NL-1:0][MW-1:0]      ldiff, lmag;
	logic [NL-1:0]              lsign;
	logic [NL-1:0][GW-1:0]      lk, ld;

	logic                  vld_s1, vld_s2;
	logic [3:0][GW-1:0]    k_s1;
	logic [NL-1:0][LNW-1:0] numer_s2;

	always_comb begin
		la[0] = cxv[3]; lb[0] = cxv[0]; lk[0] = k_s1[0]; ld[0] = h_eff;
		la[1] = cyv[3]; lb[1] = cyv[0]; lk[1] = k_s1[0]; ld[1] = h_eff;
		la[2] = cxv[1]; lb[2] = cxv[2]; lk[2] = k_s1[1]; ld[2] = h_eff;
		la[3] = cyv[1]; lb[3] = cyv[2]; lk[3] = k_s1[1]; ld[3] = h_eff;
		la[4] = cxv[0]; lb[4] = cxv[1]; lk[4] = k_s1[2]; ld[4] = w_eff;
		la[5] = cyv[0]; lb[5] = cyv[1]; lk[5] = k_s1[2]; ld[5] = w_eff;
		la[6] = cxv[2]; lb[6] = cxv[3]; lk[6] = k_s1[3]; ld[6] = w_eff;
		la[7] = cyv[2]; lb[7] = cyv[3]; lk[7] = k_s1[3]; ld[7] = w_eff;
		for (int i = 0; i < NL; i++) begin
			ldiff[i] = sext(lb[i]) - sext(la[i]);
			lsign[i] = ldiff[i][MW-1];
			lmag[i]  = lsign[i] ? (MW'(0) - ldiff[i]) : ldiff[i];
		end
	end

	// lerp pipe entry: remainder starts at the top bits of the dividend
	logic [NL-1:0][DW-1:0]  lrem0, lden;
	logic [NL-1:0][LQW-1:0] llq0, lquot;
	logic [NL-1:0]          lside;
	logic                   lerp_vld;

	always_comb begin
		for (int i = 0; i < NL; i++) begin
			lrem0[i] = numer_s2[i][LNW-1:LQW];
			llq0[i]  = numer_s2[i][LQW-1:0];
			lden[i]  = {ld[i], 1'b0};
		end
	end

	qgpm_div_pipe #(
		.LANES  (NL),
		.DEN_W  (DW),
		.Q_W    (LQW),
		.SIDE_W (NL)
	) u_lerp_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (vld_s2),
		.rem_i  (lrem0),
		.den_i  (lden),
		.lq_i   (llq0),
		.side_i (lsign),
		.vld_o  (lerp_vld),
		.quot_o (lquot),
		.side_o (lside)
	);

	logic [NL-1:0][MW-1:0] psum;

	always_comb begin
		for (int i = 0; i < NL; i++) begin
			psum[i] = lside[i] ? (sext(la[i]) - lquot[i]) : (sext(la[i]) + lquot[i]);
		end
	end

	// ---------------- intersection stages ----------------
	logic vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	logic [NL-1:0][COORD_W-1:0] pt_s3;

	logic [COORD_W-1:0] xl_s4, yl_s4, xl_s5, yl_s5, xl_s6, yl_s6;
	logic [COORD_W-1:0] xl_s7, yl_s7, xl_s8, yl_s8, xl_s9, yl_s9;
	logic signed [MW-1:0] dvx_s4, dvy_s4, dhx_s4, dhy_s4, ex_s4, ey_s4;
	logic signed [MW-1:0] dvx_s5, dvy_s5, dvx_s6, dvy_s6;
	logic signed [PW-1:0] pr0_s5, pr1_s5, pr2_s5, pr3_s5;
	logic signed [NDW-1:0] den_s6, num_s6;

	logic [NDW-1:0] den_abs, num_abs;
	logic [MW-1:0]  dvx_abs, dvy_abs;

	logic [ABSW-1:0] dabs_s7, nabs_s7, dabs_s8, dabs_s9;
	logic [DVAW-1:0] dvax_s7, dvay_s7;
	logic negx_s7, negy_s7, degen_s7, negx_s8, negy_s8, degen_s8;
	logic negx_s9, negy_s9, degen_s9;
	logic [SPLIT+DVAW-1:0]      plox_s8, ploy_s8;
	logic [ABSW-SPLIT+DVAW-1:0] phix_s8, phiy_s8;
	logic [N2W-1:0]             n2x_s9, n2y_s9;

	// magnitudes and signs for the divide
	always_comb begin
		den_abs = den_s6[NDW-1] ? (NDW'(0) - den_s6) : den_s6;
		num_abs = num_s6[NDW-1] ? (NDW'(0) - num_s6) : num_s6;
		dvx_abs = dvx_s6[MW-1] ? (MW'(0) - dvx_s6) : dvx_s6;
		dvy_abs = dvy_s6[MW-1] ? (MW'(0) - dvy_s6) : dvy_s6;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= lerp_vld;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// s1: interpolation weights
			k_s1[0] <= h_eff - gy_c;
			k_s1[1] <= gy_c;
			k_s1[2] <= gx_c;
			k_s1[3] <= w_eff - gx_c;
			// s2: rounded dividends 2*|diff|*k + d
			for (int i = 0; i < NL; i++) begin
				numer_s2[i] <= ((LNW'(lmag[i]) * LNW'(lk[i])) << 1) + LNW'(ld[i]);
			end
			// s3: side points
			for (int i = 0; i < NL; i++) begin
				pt_s3[i] <= psum[i][COORD_W-1:0];
			end
			// s4: line directions
			xl_s4  <= pt_s3[0];
			yl_s4  <= pt_s3[1];
			dvx_s4 <= sext(pt_s3[2]) - sext(pt_s3[0]);
			dvy_s4 <= sext(pt_s3[3]) - sext(pt_s3[1]);
			dhx_s4 <= sext(pt_s3[6]) - sext(pt_s3[4]);
			dhy_s4 <= sext(pt_s3[7]) - sext(pt_s3[5]);
			ex_s4  <= sext(pt_s3[4]) - sext(pt_s3[0]);
			ey_s4  <= sext(pt_s3[5]) - sext(pt_s3[1]);
			// s5: cross products
			pr0_s5 <= dvx_s4 * dhy_s4;
			pr1_s5 <= dvy_s4 * dhx_s4;
			pr2_s5 <= ex_s4 * dhy_s4;
			pr3_s5 <= ey_s4 * dhx_s4;
			dvx_s5 <= dvx_s4;
			dvy_s5 <= dvy_s4;
			xl_s5  <= xl_s4;
			yl_s5  <= yl_s4;
			// s6: determinant and numerator
			den_s6 <= {pr0_s5[PW-1], pr0_s5} - {pr1_s5[PW-1], pr1_s5};
			num_s6 <= {pr2_s5[PW-1], pr2_s5} - {pr3_s5[PW-1], pr3_s5};
			dvx_s6 <= dvx_s5;
			dvy_s6 <= dvy_s5;
			xl_s6  <= xl_s5;
			yl_s6  <= yl_s5;
			// s7: magnitudes, signs, parallel test
			dabs_s7  <= den_abs[ABSW-1:0];
			nabs_s7  <= num_abs[ABSW-1:0];
			dvax_s7  <= dvx_abs[DVAW-1:0];
			dvay_s7  <= dvy_abs[DVAW-1:0];
			negx_s7  <= num_s6[NDW-1] ^ dvx_s6[MW-1] ^ den_s6[NDW-1];
			negy_s7  <= num_s6[NDW-1] ^ dvy_s6[MW-1] ^ den_s6[NDW-1];
			degen_s7 <= (den_abs <= NDW'(DEG_LIMIT));
			xl_s7    <= xl_s6;
			yl_s7    <= yl_s6;
			// s8: split partial products |num|*|dv|
			plox_s8  <= nabs_s7[SPLIT-1:0] * dvax_s7;
			phix_s8  <= nabs_s7[ABSW-1:SPLIT] * dvax_s7;
			ploy_s8  <= nabs_s7[SPLIT-1:0] * dvay_s7;
			phiy_s8  <= nabs_s7[ABSW-1:SPLIT] * dvay_s7;
			dabs_s8  <= dabs_s7;
			negx_s8  <= negx_s7;
			negy_s8  <= negy_s7;
			degen_s8 <= degen_s7;
			xl_s8    <= xl_s7;
			yl_s8    <= yl_s7;
			// s9: dividend 2*|num|*|dv| + |det|
			n2x_s9   <= (((N2W'(phix_s8) << SPLIT) + N2W'(plox_s8)) << 1) + N2W'(dabs_s8);
			n2y_s9   <= (((N2W'(phiy_s8) << SPLIT) + N2W'(ploy_s8)) << 1) + N2W'(dabs_s8);
			dabs_s9  <= dabs_s8;
			negx_s9  <= negx_s8;
			negy_s9  <= negy_s8;
			degen_s9 <= degen_s8;
			xl_s9    <= xl_s8;
			yl_s9    <= yl_s8;
		end
	end

	// solve pipe entry; a quotient of 2^41 or more saturates up front
	logic [SDW-1:0]        dvs;
	logic [N2W-SQW-1:0]    hix, hiy;
	logic                  satx, saty;
	logic [1:0][SDW-1:0]   srem0, sden;
	logic [1:0][SQW-1:0]   slq0, squot;
	logic [SIDEW-1:0]      sside_i, sside_o;
	logic                  res_vld;

	always_comb begin
		dvs      = {dabs_s9, 1'b0};
		hix      = n2x_s9[N2W-1:SQW];
		hiy      = n2y_s9[N2W-1:SQW];
		satx     = (SDW'(hix) >= dvs);
		saty     = (SDW'(hiy) >= dvs);
		srem0[0] = satx ? '0 : SDW'(hix);
		srem0[1] = saty ? '0 : SDW'(hiy);
		slq0[0]  = n2x_s9[SQW-1:0];
		slq0[1]  = n2y_s9[SQW-1:0];
		sden[0]  = dvs;
		sden[1]  = dvs;
		sside_i  = {degen_s9, negx_s9, negy_s9, satx, saty, xl_s9, yl_s9};
	end

	qgpm_div_pipe #(
		.LANES  (2),
		.DEN_W  (SDW),
		.Q_W    (SQW),
		.SIDE_W (SIDEW)
	) u_solve_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (vld_s9),
		.rem_i  (srem0),
		.den_i  (sden),
		.lq_i   (slq0),
		.side_i (sside_i),
		.vld_o  (res_vld),
		.quot_o (squot),
		.side_o (sside_o)
	);

	// final placement and saturation
	out_item_t res;
	logic      r_degen, r_negx, r_negy, r_satx, r_saty;
	logic [COORD_W-1:0] r_xl, r_yl;

	always_comb begin
		{r_degen, r_negx, r_negy, r_satx, r_saty, r_xl, r_yl} = sside_o;
		res.degenerate = r_degen;
		res.mapped_x   = r_degen ? '0 : place(r_xl, squot[0], r_satx, r_negx);
		res.mapped_y   = r_degen ? '0 : place(r_yl, squot[1], r_saty, r_negy);
	end

	// ---------------- output register and skid ----------------
	logic out_free;
	assign out_free = !out_vld_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (out_free) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end
		end else if (res_vld) begin
			if (out_free) begin
				out_vld_q <= 1'b1;
			end else begin
				skid_vld_q <= 1'b1;
			end
		end else if (out_free) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (out_free) begin
				out_q <= skid_q;
			end
		end else if (res_vld) begin
			if (out_free) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

	// ---------------- checks ----------------
	`QGPM_ASSERT_SAME(a_skid_implies_out, clk, arst_n, skid_vld_q, out_vld_q)
	`QGPM_ASSERT_SAME(a_degen_zero, clk, arst_n, out_vld_q && out_q.degenerate, out_q.mapped_x == 0 && out_q.mapped_y == 0)
	`QGPM_ASSERT_NEXT(a_frozen_result_held, clk, arst_n, res_vld && skid_vld_q, res_vld && $stable(res))

endmodule
